FILE: sv/tsrb_pkg.sv
// shared types and constants for the tcp syn-ack reply builder
// no dependencies; imported by every module of the block
package tsrb_pkg;

    // status codes, first failed check wins
    localparam logic [2:0] STATUS_OK        = 3'd0;
    localparam logic [2:0] STATUS_NOT_IPV4  = 3'd1;
    localparam logic [2:0] STATUS_NOT_TCP   = 3'd2;
    localparam logic [2:0] STATUS_IP_OPTS   = 3'd3;
    localparam logic [2:0] STATUS_SHORT_TCP = 3'd4;

    // configuration register indexes
    localparam logic [1:0] CFG_DEFAULT_MSS  = 2'd0;
    localparam logic [1:0] CFG_REPLY_TTL    = 2'd1;
    localparam logic [1:0] CFG_REPLY_WINDOW = 2'd2;

    // configuration reset values
    localparam logic [15:0] DEFAULT_MSS_RST  = 16'd1460;
    localparam logic [7:0]  REPLY_TTL_RST    = 8'd64;
    localparam logic [15:0] REPLY_WINDOW_RST = 16'd65535;

    // frame constants
    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  PROTO_TCP      = 8'd6;
    localparam logic [3:0]  IP_IHL_NOOPT   = 4'd5;
    localparam logic [3:0]  TCP_DOFF_MIN   = 4'd5;
    localparam logic [3:0]  TCP_DOFF_REPLY = 4'd6;
    localparam logic [15:0] IP_TOTAL_LEN   = 16'd44;
    localparam logic [15:0] TCP_LEN        = 16'd24;
    localparam logic [7:0]  TCP_FLAGS_SA   = 8'h12;
    localparam logic [15:0] MSS_OPT_HDR    = 16'h0204;

    // reply header fields handed to the checksum unit
    typedef struct packed {
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [31:0] seq;
        logic [31:0] ack;
        logic [15:0] mss;
        logic [7:0]  byte12;
    } reply_hdr_t;

    // settings that shape the reply headers
    typedef struct packed {
        logic [15:0] default_mss;
        logic [7:0]  ttl;
        logic [15:0] window;
    } reply_cfg_t;

endpackage

FILE: sv/tcp_synack_reply_builder.sv
// top level of the tcp syn-ack reply builder: input register, check, checksums, result register
// depends on tsrb_pkg, tsrb_check and tsrb_csum
//
// Builds the syn-ack answer to one ipv4 tcp syn per transaction. Each input
// transaction carries the syn header fields plus the cookie and mss from an
// external cookie generator; each gives exactly one result transaction. The
// result carries a status (0 ok, 1 not ipv4, 2 not tcp, 3 ip options,
// 4 short tcp header); on a failed check every reply field is zero. A passing
// syn gives swapped addresses and ports, seq = cookie, ack = client seq + 1,
// the mss (default_mss when the cookie mss is zero), and the ip and tcp
// checksums of the 20 byte ip header and 24 byte tcp header of the reply.
// A syn passes one input register, then the checks, adder trees and fold before
// the result register. Throughput is one transaction per cycle while the result
// side keeps taking data; both registers advance whenever the result side takes
// data or the result register is empty, so a waiting result does not stop the
// next syn being captured into an empty input register. Configuration writes
// (index 0 default_mss, 1 reply_ttl, 2 reply_window, others ignored) take
// effect at once and are meant for idle periods only.
module tcp_synack_reply_builder
    import tsrb_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    // configuration write port
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata,

    // syn transactions in
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_ether_type,
    input  logic [15:0] s_ip_word0,
    input  logic [7:0]  s_ip_protocol,
    input  logic [15:0] s_ip_frag_word,
    input  logic [31:0] s_src_ip,
    input  logic [31:0] s_dst_ip,
    input  logic [15:0] s_src_port,
    input  logic [15:0] s_dst_port,
    input  logic [7:0]  s_tcp_byte12,
    input  logic [31:0] s_peer_seq,
    input  logic [31:0] s_cookie_isn,
    input  logic [15:0] s_cookie_mss,

    // reply transactions out
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [31:0] m_reply_src_ip,
    output logic [31:0] m_reply_dst_ip,
    output logic [15:0] m_reply_src_port,
    output logic [15:0] m_reply_dst_port,
    output logic [31:0] m_reply_seq,
    output logic [31:0] m_reply_ack,
    output logic [15:0] m_reply_mss,
    output logic [7:0]  m_reply_tcp_byte12,
    output logic [15:0] m_ip_checksum,
    output logic [15:0] m_tcp_checksum
);

    // configuration registers
    reply_cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.default_mss <= DEFAULT_MSS_RST;
            cfg_reg.ttl         <= REPLY_TTL_RST;
            cfg_reg.window      <= REPLY_WINDOW_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_DEFAULT_MSS:  cfg_reg.default_mss <= cfg_wdata;
                CFG_REPLY_TTL:    cfg_reg.ttl         <= cfg_wdata[7:0];
                CFG_REPLY_WINDOW: cfg_reg.window      <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // pipeline flow: result stage frees when empty or drained
    logic in_vld_reg;
    logic out_vld_reg;
    logic out_free;
    logic in_adv;

    assign out_free = !out_vld_reg || m_ready;
    assign in_adv   = in_vld_reg && out_free;
    assign s_ready  = !in_vld_reg || out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_vld_reg <= s_valid;
            end
            if (out_free) begin
                out_vld_reg <= in_vld_reg;
            end
        end
    end

    // input register, payload only
    logic [15:0] ether_type_reg;
    logic [15:0] ip_word0_reg;
    logic [7:0]  ip_protocol_reg;
    logic [15:0] ip_frag_word_reg;
    logic [31:0] src_ip_reg;
    logic [31:0] dst_ip_reg;
    logic [15:0] src_port_reg;
    logic [15:0] dst_port_reg;
    logic [7:0]  tcp_byte12_reg;
    logic [31:0] peer_seq_reg;
    logic [31:0] cookie_isn_reg;
    logic [15:0] cookie_mss_reg;

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            ether_type_reg   <= s_ether_type;
            ip_word0_reg     <= s_ip_word0;
            ip_protocol_reg  <= s_ip_protocol;
            ip_frag_word_reg <= s_ip_frag_word;
            src_ip_reg       <= s_src_ip;
            dst_ip_reg       <= s_dst_ip;
            src_port_reg     <= s_src_port;
            dst_port_reg     <= s_dst_port;
            tcp_byte12_reg   <= s_tcp_byte12;
            peer_seq_reg     <= s_peer_seq;
            cookie_isn_reg   <= s_cookie_isn;
            cookie_mss_reg   <= s_cookie_mss;
        end
    end

    // frame checks
    logic [2:0] status;

    tsrb_check u_check (
        .ether_type  (ether_type_reg),
        .ip_word0    (ip_word0_reg),
        .ip_protocol (ip_protocol_reg),
        .tcp_byte12  (tcp_byte12_reg),
        .status      (status)
    );

    // reply header: swap addresses and ports, ack one past the client seq
    reply_hdr_t hdr;

    always_comb begin
        hdr.src_ip   = dst_ip_reg;
        hdr.dst_ip   = src_ip_reg;
        hdr.src_port = dst_port_reg;
        hdr.dst_port = src_port_reg;
        hdr.seq      = cookie_isn_reg;
        hdr.ack      = peer_seq_reg + 32'd1;
        hdr.mss      = (cookie_mss_reg == 16'd0) ? cfg_reg.default_mss : cookie_mss_reg;
        hdr.byte12   = {TCP_DOFF_REPLY, tcp_byte12_reg[3:0]};
    end

    logic [15:0] ip_csum;
    logic [15:0] tcp_csum;

    tsrb_csum u_csum (
        .hdr          (hdr),
        .cfg          (cfg_reg),
        .ip_word0     (ip_word0_reg),
        .ip_frag_word (ip_frag_word_reg),
        .ip_checksum  (ip_csum),
        .tcp_checksum (tcp_csum)
    );

    // result register; a failed check zeroes every reply field
    logic        pass;
    logic [2:0]  status_reg;
    reply_hdr_t  hdr_reg;
    logic [15:0] ip_csum_reg;
    logic [15:0] tcp_csum_reg;

    assign pass = (status == STATUS_OK);

    always_ff @(posedge aclk) begin
        if (in_adv) begin
            status_reg   <= status;
            hdr_reg      <= pass ? hdr : '0;
            ip_csum_reg  <= pass ? ip_csum : 16'd0;
            tcp_csum_reg <= pass ? tcp_csum : 16'd0;
        end
    end

    assign m_valid            = out_vld_reg;
    assign m_status           = status_reg;
    assign m_reply_src_ip     = hdr_reg.src_ip;
    assign m_reply_dst_ip     = hdr_reg.dst_ip;
    assign m_reply_src_port   = hdr_reg.src_port;
    assign m_reply_dst_port   = hdr_reg.dst_port;
    assign m_reply_seq        = hdr_reg.seq;
    assign m_reply_ack        = hdr_reg.ack;
    assign m_reply_mss        = hdr_reg.mss;
    assign m_reply_tcp_byte12 = hdr_reg.byte12;
    assign m_ip_checksum      = ip_csum_reg;
    assign m_tcp_checksum     = tcp_csum_reg;

endmodule

FILE: sv/tsrb_check.sv
// frame checks on a captured syn: ethertype, protocol, ip options, tcp header length
// depends on tsrb_pkg
module tsrb_check
    import tsrb_pkg::*;
(
    input  logic [15:0] ether_type,
    input  logic [15:0] ip_word0,
    input  logic [7:0]  ip_protocol,
    input  logic [7:0]  tcp_byte12,
    output logic [2:0]  status
);

    always_comb begin
        if (ether_type != ETHERTYPE_IPV4) begin
            status = STATUS_NOT_IPV4;
        end else if (ip_protocol != PROTO_TCP) begin
            status = STATUS_NOT_TCP;
        end else if (ip_word0[11:8] != IP_IHL_NOOPT) begin
            status = STATUS_IP_OPTS;
        end else if (tcp_byte12[7:4] < TCP_DOFF_MIN) begin
            status = STATUS_SHORT_TCP;
        end else begin
            status = STATUS_OK;
        end
    end

endmodule

FILE: sv/tsrb_csum.sv
// ones complement ip header and tcp checksums of the syn-ack reply
// depends on tsrb_pkg
module tsrb_csum
    import tsrb_pkg::*;
(
    input  reply_hdr_t  hdr,
    input  reply_cfg_t  cfg,
    input  logic [15:0] ip_word0,
    input  logic [15:0] ip_frag_word,
    output logic [15:0] ip_checksum,
    output logic [15:0] tcp_checksum
);

    // at most 16 words summed, so 20 bits never overflow
    function automatic logic [15:0] fold_not(input logic [19:0] acc);
        logic [16:0] f1;
        logic [15:0] f2;
        f1 = {1'b0, acc[15:0]} + {13'd0, acc[19:16]};
        f2 = f1[15:0] + {15'd0, f1[16]};
        return ~f2;
    endfunction

    logic [19:0] ip_sum;
    logic [19:0] tcp_sum;

    always_comb begin
        ip_sum = {4'd0, ip_word0} + {4'd0, IP_TOTAL_LEN} + {4'd0, ip_frag_word}
               + {4'd0, cfg.ttl, PROTO_TCP}
               + {4'd0, hdr.src_ip[31:16]} + {4'd0, hdr.src_ip[15:0]}
               + {4'd0, hdr.dst_ip[31:16]} + {4'd0, hdr.dst_ip[15:0]};

        tcp_sum = {4'd0, hdr.src_ip[31:16]} + {4'd0, hdr.src_ip[15:0]}
                + {4'd0, hdr.dst_ip[31:16]} + {4'd0, hdr.dst_ip[15:0]}
                + {12'd0, PROTO_TCP} + {4'd0, TCP_LEN}
                + {4'd0, hdr.src_port} + {4'd0, hdr.dst_port}
                + {4'd0, hdr.seq[31:16]} + {4'd0, hdr.seq[15:0]}
                + {4'd0, hdr.ack[31:16]} + {4'd0, hdr.ack[15:0]}
                + {4'd0, hdr.byte12, TCP_FLAGS_SA} + {4'd0, cfg.window}
                + {4'd0, MSS_OPT_HDR} + {4'd0, hdr.mss};
    end

    assign ip_checksum  = fold_not(ip_sum);
    assign tcp_checksum = fold_not(tcp_sum);

endmodule

FILE: test/tcp_synack_reply_builder_test.sv
// self-checking testbench for tcp_synack_reply_builder: directed header checks,
// checksum corners, back-pressure and randomised traffic against a local predictor
// depends on tsrb_pkg and the tcp_synack_reply_builder rtl
`timescale 1ns / 100ps

module tcp_synack_reply_builder_test;
    import tsrb_pkg::*;

    localparam int         CLK_PERIOD     = 8;
    localparam int         RESET_CYCLES   = 9;
    localparam int         PIPE_LATENCY   = 2;
    localparam int         RUN_LIMIT_NS   = 4_000_000;
    localparam int         MAX_REPORTS    = 10;
    localparam int         HOLD_CYCLES    = 300;
    localparam int         RANDOM_PHASES  = 5;
    localparam int         SYNS_PER_PHASE = 222;
    // index 3 has no register behind it, writes there must be dropped
    localparam logic [1:0] CFG_UNUSED_IDX = 2'd3;

    // one syn as it arrives, with the cookie generator's answer
    typedef struct packed {
        logic [15:0] ether_type;
        logic [15:0] ip_word0;
        logic [7:0]  ip_protocol;
        logic [15:0] ip_frag_word;
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [7:0]  tcp_byte12;
        logic [31:0] peer_seq;
        logic [31:0] cookie_isn;
        logic [15:0] cookie_mss;
    } syn_fields_t;

    // one reply transaction
    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [31:0] seq;
        logic [31:0] ack;
        logic [15:0] mss;
        logic [7:0]  byte12;
        logic [15:0] ip_csum;
        logic [15:0] tcp_csum;
    } reply_fields_t;

    logic          aclk;
    logic          aresetn;
    logic          cfg_wr_en;
    logic [1:0]    cfg_index;
    logic [15:0]   cfg_wdata;
    logic          s_valid;
    logic          s_ready;
    syn_fields_t   syn_bus;
    logic          m_valid;
    logic          m_ready;
    reply_fields_t reply_bus;

    // local copy of the settings, tracks every write
    logic [15:0] cfg_mss    = DEFAULT_MSS_RST;
    logic [7:0]  cfg_ttl    = REPLY_TTL_RST;
    logic [15:0] cfg_window = REPLY_WINDOW_RST;

    // replies still owed by the block, oldest first
    reply_fields_t owed_replies[$];

    int syns_sent;
    int replies_seen;
    int replies_built;
    int replies_rejected;
    int input_stalls;
    int mismatches;
    int burst_left;

    // receiver state
    int          rx_hold_req;
    int          rx_hold_left;
    logic [15:0] rx_pattern;
    logic [6:0]  rx_tick;

    reply_fields_t seen_reply;
    reply_fields_t want_reply;

    tcp_synack_reply_builder u_top (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_index          (cfg_index),
        .cfg_wdata          (cfg_wdata),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_ether_type       (syn_bus.ether_type),
        .s_ip_word0         (syn_bus.ip_word0),
        .s_ip_protocol      (syn_bus.ip_protocol),
        .s_ip_frag_word     (syn_bus.ip_frag_word),
        .s_src_ip           (syn_bus.src_ip),
        .s_dst_ip           (syn_bus.dst_ip),
        .s_src_port         (syn_bus.src_port),
        .s_dst_port         (syn_bus.dst_port),
        .s_tcp_byte12       (syn_bus.tcp_byte12),
        .s_peer_seq         (syn_bus.peer_seq),
        .s_cookie_isn       (syn_bus.cookie_isn),
        .s_cookie_mss       (syn_bus.cookie_mss),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_status           (reply_bus.status),
        .m_reply_src_ip     (reply_bus.src_ip),
        .m_reply_dst_ip     (reply_bus.dst_ip),
        .m_reply_src_port   (reply_bus.src_port),
        .m_reply_dst_port   (reply_bus.dst_port),
        .m_reply_seq        (reply_bus.seq),
        .m_reply_ack        (reply_bus.ack),
        .m_reply_mss        (reply_bus.mss),
        .m_reply_tcp_byte12 (reply_bus.byte12),
        .m_ip_checksum      (reply_bus.ip_csum),
        .m_tcp_checksum     (reply_bus.tcp_csum)
    );

    initial aclk = 1'b0;
    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // ---------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------

    // end-around carry fold, then invert; a folded sum of all ones gives zero
    function automatic logic [15:0] fold_complement(input logic [31:0] acc);
        while (acc[31:16] != 16'd0)
            acc = acc[15:0] + acc[31:16];
        return ~acc[15:0];
    endfunction

    function automatic reply_fields_t predict_synack(input syn_fields_t syn);
        reply_fields_t r;
        logic [31:0]   ip_acc;
        logic [31:0]   tcp_acc;
        r = '0;
        if (syn.ether_type != ETHERTYPE_IPV4) begin
            r.status = STATUS_NOT_IPV4;
        end else if (syn.ip_protocol != PROTO_TCP) begin
            r.status = STATUS_NOT_TCP;
        end else if (syn.ip_word0[11:8] != IP_IHL_NOOPT) begin
            r.status = STATUS_IP_OPTS;
        end else if (syn.tcp_byte12[7:4] < TCP_DOFF_MIN) begin
            r.status = STATUS_SHORT_TCP;
        end else begin
            r.status   = STATUS_OK;
            r.src_ip   = syn.dst_ip;
            r.dst_ip   = syn.src_ip;
            r.src_port = syn.dst_port;
            r.dst_port = syn.src_port;
            r.seq      = syn.cookie_isn;
            r.ack      = syn.peer_seq + 32'd1;
            r.mss      = (syn.cookie_mss == 16'd0) ? cfg_mss : syn.cookie_mss;
            r.byte12   = {TCP_DOFF_REPLY, syn.tcp_byte12[3:0]};
            // ip header: id and checksum words are zero
            ip_acc = syn.ip_word0 + IP_TOTAL_LEN + syn.ip_frag_word
                   + {cfg_ttl, PROTO_TCP}
                   + r.src_ip[31:16] + r.src_ip[15:0]
                   + r.dst_ip[31:16] + r.dst_ip[15:0];
            // pseudo-header, then the 24 byte tcp header with the mss option
            tcp_acc = r.src_ip[31:16] + r.src_ip[15:0]
                    + r.dst_ip[31:16] + r.dst_ip[15:0]
                    + PROTO_TCP + TCP_LEN + r.src_port + r.dst_port
                    + r.seq[31:16] + r.seq[15:0] + r.ack[31:16] + r.ack[15:0]
                    + {r.byte12, TCP_FLAGS_SA} + cfg_window + MSS_OPT_HDR + r.mss;
            r.ip_csum  = fold_complement(ip_acc);
            r.tcp_csum = fold_complement(tcp_acc);
        end
        return r;
    endfunction

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------

    // an ordinary well-formed syn
    function automatic syn_fields_t plain_syn();
        syn_fields_t s;
        s.ether_type   = ETHERTYPE_IPV4;
        s.ip_word0     = 16'h4500;
        s.ip_protocol  = PROTO_TCP;
        s.ip_frag_word = 16'h4000;
        s.src_ip       = 32'hC0A8_0A01;
        s.dst_ip       = 32'h0A00_0001;
        s.src_port     = 16'd51234;
        s.dst_port     = 16'd80;
        s.tcp_byte12   = 8'hA0;
        s.peer_seq     = 32'h1234_5678;
        s.cookie_isn   = 32'h9ABC_DEF0;
        s.cookie_mss   = 16'd1400;
        return s;
    endfunction

    // mostly well-formed syns with random content, some with one check broken,
    // some pure noise
    function automatic syn_fields_t random_syn();
        syn_fields_t s;
        int          kind;
        kind = $urandom_range(0, 9);
        s.ether_type   = 16'($urandom);
        s.ip_word0     = 16'($urandom);
        s.ip_protocol  = 8'($urandom);
        s.ip_frag_word = 16'($urandom);
        s.src_ip       = $urandom;
        s.dst_ip       = $urandom;
        s.src_port     = 16'($urandom);
        s.dst_port     = 16'($urandom);
        s.tcp_byte12   = 8'($urandom);
        s.peer_seq     = ($urandom_range(0, 15) == 0) ? 32'hFFFF_FFFF : $urandom;
        s.cookie_isn   = $urandom;
        s.cookie_mss   = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom);
        if (kind < 9) begin
            s.ether_type       = ETHERTYPE_IPV4;
            s.ip_protocol      = PROTO_TCP;
            s.ip_word0[11:8]   = IP_IHL_NOOPT;
            s.tcp_byte12[7:4]  = 4'($urandom_range(5, 15));
        end
        // break exactly one check
        if (kind == 8) begin
            case ($urandom_range(0, 3))
                0: s.ether_type      = 16'($urandom_range(0, 16'h07FF));
                1: s.ip_protocol     = 8'($urandom_range(7, 255));
                2: s.ip_word0[11:8]  = 4'($urandom_range(6, 15));
                default: s.tcp_byte12[7:4] = 4'($urandom_range(0, 4));
            endcase
        end
        return s;
    endfunction

    // offer one syn, in bursts with random gaps, and log the owed reply once taken
    task automatic offer_syn(input syn_fields_t syn);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        s_valid <= 1'b1;
        syn_bus <= syn;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        owed_replies.push_back(predict_synack(syn));
        syns_sent++;
    endtask

    // drop valid and let every owed reply come back
    task automatic drain_replies();
        s_valid <= 1'b0;
        while (owed_replies.size() != 0) @(posedge aclk);
        repeat (PIPE_LATENCY + 2) @(posedge aclk);
    endtask

    // write all three registers plus the unused index; upper ttl data bits carry junk
    task automatic apply_settings(input logic [15:0] mss, input logic [7:0] ttl,
                                  input logic [15:0] window);
        logic [7:0] junk;
        junk = 8'($urandom);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_DEFAULT_MSS;
        cfg_wdata <= mss;
        @(posedge aclk);
        cfg_index <= CFG_REPLY_TTL;
        cfg_wdata <= {junk, ttl};
        @(posedge aclk);
        cfg_index <= CFG_REPLY_WINDOW;
        cfg_wdata <= window;
        @(posedge aclk);
        cfg_index <= CFG_UNUSED_IDX;
        cfg_wdata <= 16'($urandom);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        cfg_mss    = mss;
        cfg_ttl    = ttl;
        cfg_window = window;
    endtask

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    // reset settings untouched: plain, all-ones, all-zeros and odd-version syns
    task automatic test_reset_settings();
        syn_fields_t s;
        offer_syn(plain_syn());
        // every field at its top, ack wraps to zero
        s = '1;
        s.ether_type     = ETHERTYPE_IPV4;
        s.ip_protocol    = PROTO_TCP;
        s.ip_word0[11:8] = IP_IHL_NOOPT;
        offer_syn(s);
        // every free field zero, cookie mss zero picks the default
        s = '0;
        s.ether_type     = ETHERTYPE_IPV4;
        s.ip_protocol    = PROTO_TCP;
        s.ip_word0[11:8] = IP_IHL_NOOPT;
        s.tcp_byte12     = {TCP_DOFF_MIN, 4'h0};
        offer_syn(s);
        // version nibble is not checked
        s = plain_syn();
        s.ip_word0 = 16'h65B8;
        offer_syn(s);
        drain_replies();
    endtask

    // each check failing alone, checks failing together, and the doff boundary
    task automatic test_header_checks();
        syn_fields_t s;
        s = plain_syn(); s.ether_type = 16'h86DD;        offer_syn(s);
        s = plain_syn(); s.ether_type = 16'h0000;        offer_syn(s);
        s = plain_syn(); s.ether_type = 16'hFFFF;        offer_syn(s);
        s = plain_syn(); s.ip_protocol = 8'd17;          offer_syn(s);
        s = plain_syn(); s.ip_protocol = 8'hFF;          offer_syn(s);
        s = plain_syn(); s.ip_word0 = 16'h4600;          offer_syn(s);
        s = plain_syn(); s.ip_word0 = 16'h4FFF;          offer_syn(s);
        s = plain_syn(); s.ip_word0 = 16'h4400;          offer_syn(s);
        s = plain_syn(); s.tcp_byte12 = 8'h4F;           offer_syn(s);
        s = plain_syn(); s.tcp_byte12 = 8'h00;           offer_syn(s);
        // first failing check wins
        s = '0;                                          offer_syn(s);
        s = plain_syn(); s.ip_protocol = 8'd1; s.ip_word0 = 16'h4700; offer_syn(s);
        s = plain_syn(); s.ip_word0 = 16'h4000; s.tcp_byte12 = 8'h10; offer_syn(s);
        // smallest data offset that passes, reserved nibble kept
        s = plain_syn(); s.tcp_byte12 = 8'h5C;           offer_syn(s);
        drain_replies();
    endtask

    // settings at both extremes, default mss taken over, and checksums whose
    // folded sum is all ones so the checksum comes out as zero
    task automatic test_checksum_corners();
        syn_fields_t   s;
        reply_fields_t r;
        for (int pass = 0; pass < 2; pass++) begin
            if (pass == 0)
                apply_settings(16'h0000, 8'h00, 16'h0000);
            else
                apply_settings(16'hFFFF, 8'hFF, 16'hFFFF);
            s = plain_syn();
            s.cookie_mss = 16'd0;
            offer_syn(s);
            // zero the free words, then put each complement back in them
            s = plain_syn();
            s.ip_frag_word = 16'd0;
            s.src_port     = 16'd0;
            r = predict_synack(s);
            s.ip_frag_word = r.ip_csum;
            s.src_port     = r.tcp_csum;
            offer_syn(s);
            drain_replies();
        end
    endtask

    // receiver holds off for a long stretch while syns keep coming
    task automatic test_backpressure();
        rx_hold_req = HOLD_CYCLES;
        repeat (40) offer_syn(random_syn());
        drain_replies();
    endtask

    // random traffic over several settings, extremes first
    task automatic test_random_traffic();
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: apply_settings(16'h0000, 8'h00, 16'h0000);
                1: apply_settings(16'hFFFF, 8'hFF, 16'hFFFF);
                2: apply_settings(DEFAULT_MSS_RST, REPLY_TTL_RST, REPLY_WINDOW_RST);
                default: apply_settings(16'($urandom), 8'($urandom), 16'($urandom));
            endcase
            repeat (SYNS_PER_PHASE) offer_syn(random_syn());
            drain_replies();
        end
    endtask

    // ---------------------------------------------------------------
    // result side
    // ---------------------------------------------------------------

    // receiver: long hold when asked, else a fresh stall pattern each time rx_tick wraps,
    // a quarter of them with no stalls at all
    always @(posedge aclk) begin
        if (rx_hold_req != 0) begin
            rx_hold_left = rx_hold_req;
            rx_hold_req  = 0;
        end
        if (rx_hold_left != 0) begin
            m_ready <= 1'b0;
            rx_hold_left--;
        end else begin
            if (rx_tick == 7'd0)
                rx_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h1);
            m_ready <= rx_pattern[rx_tick[3:0]];
            rx_tick++;
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t reply %0d: %s expected %h got %h",
                         $realtime, replies_seen, name, want, got);
        end
    endtask

    // compare each reply transaction with the oldest owed one
    always @(posedge aclk) begin
        if (aresetn && s_valid && !s_ready)
            input_stalls++;
        if (aresetn && m_valid && m_ready) begin
            seen_reply = reply_bus;
            if (owed_replies.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t unexpected reply, status %0d", $realtime, seen_reply.status);
            end else begin
                want_reply = owed_replies.pop_front();
                if (want_reply.status == STATUS_OK)
                    replies_built++;
                else
                    replies_rejected++;
                check_field("status",   32'(want_reply.status),   32'(seen_reply.status));
                check_field("src_ip",   want_reply.src_ip,        seen_reply.src_ip);
                check_field("dst_ip",   want_reply.dst_ip,        seen_reply.dst_ip);
                check_field("src_port", 32'(want_reply.src_port), 32'(seen_reply.src_port));
                check_field("dst_port", 32'(want_reply.dst_port), 32'(seen_reply.dst_port));
                check_field("seq",      want_reply.seq,           seen_reply.seq);
                check_field("ack",      want_reply.ack,           seen_reply.ack);
                check_field("mss",      32'(want_reply.mss),      32'(seen_reply.mss));
                check_field("byte12",   32'(want_reply.byte12),   32'(seen_reply.byte12));
                check_field("ip_csum",  32'(want_reply.ip_csum),  32'(seen_reply.ip_csum));
                check_field("tcp_csum", 32'(want_reply.tcp_csum), 32'(seen_reply.tcp_csum));
            end
            replies_seen++;
        end
    end

    // ---------------------------------------------------------------
    // run
    // ---------------------------------------------------------------

    initial begin
        aresetn   <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= CFG_DEFAULT_MSS;
        cfg_wdata <= 16'd0;
        s_valid   <= 1'b0;
        syn_bus   <= '0;
        m_ready   <= 1'b0;
        rx_hold_req  = 0;
        rx_hold_left = 0;
        rx_tick      = 7'd0;
        rx_pattern   = 16'hFFFF;
        burst_left   = 0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        test_reset_settings();
        test_header_checks();
        test_checksum_corners();
        test_backpressure();
        test_random_traffic();
        drain_replies();

        $display("run covered %0d syn transactions and %0d replies: %0d built, %0d rejected",
                 syns_sent, replies_seen, replies_built, replies_rejected);
        $display("settings swept through both extremes, %0d cycles of input stall, %0d mismatches",
                 input_stalls, mismatches);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // watchdog against a hung handshake
    initial begin
        #(RUN_LIMIT_NS);
        $display("timeout with %0d replies still owed", owed_replies.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule
